@@ rtl/p16_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p16_pkg: shared types and constants for the posit16 es=1 add/sub/mul unit
// Operation codes, special patterns and the decoded-operand structure.
// ----------------------------------------------------------------------------
package p16_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  localparam logic [15:0] NAR_PAT    = 16'h8000;
  localparam logic [15:0] MAXPOS_MAG = 16'h7FFF;
  localparam logic [15:0] MINPOS_MAG = 16'h0001;

  // scale of a decoded posit lies in -28..28; sums in -56..56
  typedef struct packed {
    logic              neg;
    logic signed [7:0] scale;
    logic [12:0]       sig;
  } dec_t;

  // value = 1.frac * 2^scale, frac left-aligned in 42 bits, sticky below
  typedef struct packed {
    logic              special;
    logic [15:0]       special_val;
    logic              neg;
    logic signed [7:0] scale;
    logic [41:0]       frac;
    logic              sticky;
  } norm_t;

  function automatic logic [15:0] neg16(input logic [15:0] p);
    neg16 = 16'(~p + 16'd1);
  endfunction

  // p must be neither zero nor NaR
  function automatic dec_t decode(input logic [15:0] p);
    dec_t        d;
    logic [15:0] v;
    logic [15:0] t;
    logic        r;
    logic [4:0]  m;
    logic [4:0]  k_pos;
    logic signed [6:0] k;
    logic [15:0] rest;
    d.neg = p[15];
    v = p[15] ? neg16(p) : p;
    r = v[14];
    t = r ? ~v : v;
    t[15] = 1'b0;
    m = 5'd15;
    for (int i = 14; i >= 0; i--) begin
      if (t[i] && m == 5'd15) m = 5'(14 - i);
    end
    k_pos = m;
    k = r ? 7'(signed'({2'b0, k_pos}) - 7'sd1) : -7'(signed'({2'b0, k_pos}));
    // bits after regime and terminator: shift them to the top
    rest = 16'(v << (m + 5'd2));
    d.scale = 8'(2 * k) + 8'(rest[15]);
    d.sig = {1'b1, rest[14:3]};
    decode = d;
  endfunction

endpackage
`default_nettype wire

@@ rtl/posit16_add_sub_mul_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// posit16_add_sub_mul_unit: posit16 es=1 add / subtract / multiply
// Four-stage pipeline: decode, arithmetic, normalize, encode and round.
// ----------------------------------------------------------------------------
// One operand pair enters every cycle while in_ready is high. The pipeline
// advances whenever the output register is empty or being drained, so a stall
// on out_ready holds every stage in place.
module posit16_add_sub_mul_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_result
);
  import p16_pkg::*;

  logic        en;
  logic        v1, mul1, sp1, v3;
  logic [15:0] sv1;
  dec_t        da1, db1;
  norm_t       n3;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  p16_decode u_dec (
    .clk, .rst_n, .en, .vin(in_valid), .mode(in_mode), .a_in(in_operand_a),
    .b_in(in_operand_b), .v_r(v1), .mul_r(mul1), .special_r(sp1),
    .special_val_r(sv1), .da_r(da1), .db_r(db1)
  );

  p16_arith u_ari (
    .clk, .rst_n, .en, .vin(v1), .mul(mul1), .special(sp1),
    .special_val(sv1), .da(da1), .db(db1), .v_r(v3), .n_r(n3)
  );

  p16_encode u_enc (
    .clk, .rst_n, .en, .vin(v3), .n(n3), .v_r(out_valid), .res_r(out_result)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("ready low with empty output");

endmodule
`default_nettype wire

@@ rtl/p16_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p16_decode: stage 1
// Resolves special operands, swaps for add/sub and decodes both operands.
// ----------------------------------------------------------------------------
module p16_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vin,
  input  wire logic [1:0]        mode,
  input  wire logic [15:0]       a_in,
  input  wire logic [15:0]       b_in,
  output logic                   v_r,
  output logic                   mul_r,
  output logic                   special_r,
  output logic [15:0]            special_val_r,
  output p16_pkg::dec_t          da_r,
  output p16_pkg::dec_t          db_r
);
  import p16_pkg::*;

  logic [15:0] b, a2, b2, absa, absb;
  logic        spec_nxt;
  logic [15:0] sval_nxt;

  always_comb begin
    b = (mode == OP_SUB) ? neg16(b_in) : b_in;
    absa = a_in[15] ? neg16(a_in) : a_in;
    absb = b[15] ? neg16(b) : b;
    a2 = a_in;
    b2 = b;
    if (mode != OP_MUL && absa < absb) begin
      a2 = b;
      b2 = a_in;
    end
    spec_nxt = 1'b1;
    sval_nxt = 16'd0;
    if (mode != OP_ADD && mode != OP_SUB && mode != OP_MUL) sval_nxt = NAR_PAT;
    else if (a_in == NAR_PAT || b == NAR_PAT) sval_nxt = NAR_PAT;
    else if (mode == OP_MUL) begin
      if (a_in != 16'd0 && b != 16'd0) spec_nxt = 1'b0;
    end else if (a_in == 16'd0) sval_nxt = b;
    else if (b == 16'd0) sval_nxt = a_in;
    else spec_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
    if (en) begin
      mul_r         <= (mode == OP_MUL);
      special_r     <= spec_nxt;
      special_val_r <= sval_nxt;
      da_r          <= decode(a2);
      db_r          <= decode(b2);
    end
  end

endmodule
`default_nettype wire

@@ rtl/p16_arith.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p16_arith: stages 2 and 3
// Aligns and adds, or multiplies, then normalizes to a leading one.
// ----------------------------------------------------------------------------
module p16_arith (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         vin,
  input  wire logic         mul,
  input  wire logic         special,
  input  wire logic [15:0]  special_val,
  input  wire p16_pkg::dec_t da,
  input  wire p16_pkg::dec_t db,
  output logic              v_r,
  output p16_pkg::norm_t    n_r
);
  import p16_pkg::*;

  // stage 2: raw magnitude, 30 bits, unit point at bit 28 (add) or product
  logic              v2_r, sp2_r, mul2_r, neg2_r;
  logic [15:0]       sv2_r;
  logic signed [7:0] sc2_r;
  logic [29:0]       m2_r;
  logic              st2_r;

  logic [8:0]  d;
  logic [28:0] ma, mb, mbs, lostmask;
  logic        lost;
  logic [29:0] m_nxt;

  always_comb begin
    d = 9'(signed'(da.scale) - signed'(db.scale));
    ma = {da.sig, 16'd0};
    mb = {db.sig, 16'd0};
    lostmask = 29'd0;
    if (d >= 9'd29) begin
      mbs = 29'd0;
      lost = 1'b1;
    end else begin
      lostmask = ~(29'h1FFFFFFF << d[4:0]);
      mbs = mb >> d[4:0];
      lost = |(mb & lostmask);
    end
    // sticky kept separate; for subtraction it borrows below the point
    if (da.neg == db.neg) m_nxt = 30'(ma) + 30'(mbs);
    else m_nxt = 30'(ma) - 30'(mbs) - 30'(lost);
    if (mul) m_nxt = 30'(26'(da.sig) * 26'(db.sig));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= vin;
    if (en) begin
      sp2_r  <= special;
      sv2_r  <= special_val;
      mul2_r <= mul;
      neg2_r <= mul ? (da.neg ^ db.neg) : da.neg;
      sc2_r  <= mul ? 8'(da.scale + db.scale) : da.scale;
      m2_r   <= m_nxt;
      st2_r  <= mul ? 1'b0 : lost;
    end
  end

  // stage 3: leading-one search and normalize
  logic [4:0]  p;
  logic        zero;
  logic [41:0] fr;
  norm_t       n_nxt;

  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 30; i++) if (m2_r[i]) p = 5'(i);
    zero = (m2_r == 30'd0) && !st2_r;
    fr = 42'({m2_r, 12'd0} << (6'd30 - 6'(p)));
    n_nxt.special = sp2_r | zero;
    n_nxt.special_val = sp2_r ? sv2_r : 16'd0;
    n_nxt.neg = neg2_r;
    n_nxt.scale = mul2_r ? 8'(sc2_r + 8'(p) - 8'sd24)
                         : 8'(sc2_r + 8'(p) - 8'sd28);
    n_nxt.frac = fr;
    n_nxt.sticky = st2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= v2_r;
    if (en) n_r <= n_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/p16_encode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p16_encode: stage 4
// Lays out regime, exponent and fraction and rounds to nearest even.
// ----------------------------------------------------------------------------
module p16_encode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vin,
  input  wire p16_pkg::norm_t n,
  output logic               v_r,
  output logic [15:0]        res_r
);
  import p16_pkg::*;

  logic signed [7:0] k;
  logic              e;
  logic [4:0]        rl;
  logic [63:0]       field;
  logic [15:0]       mag, r;
  logic              guard, rest;

  always_comb begin
    k = n.scale >>> 1;
    e = n.scale[0];
    rl = 5'd0;
    field = 64'd0;
    mag = 16'd0;
    guard = 1'b0;
    rest = 1'b0;
    if (k >= 8'sd14) mag = MAXPOS_MAG;
    else if (k < -8'sd14) mag = MINPOS_MAG;
    else begin
      // field top-aligned at bit 63: regime, e, fraction
      if (k >= 8'sd0) begin
        rl = 5'(k) + 5'd2;
        field = ~(64'h7FFF_FFFF_FFFF_FFFF >> (5'(k) + 5'd1));
        field = field & ~(64'h8000_0000_0000_0000 >> rl[4:0] + 6'd0) ;
        field = field & ~(64'h8000_0000_0000_0000 >> (5'(k) + 5'd1));
      end else begin
        rl = 5'(-k) + 5'd1;
        field = 64'h8000_0000_0000_0000 >> (rl - 5'd1);
      end
      field = field | ({e, n.frac, 21'd0} >> rl);
      mag = {1'b0, field[63:49]};
      guard = field[48];
      rest = |field[47:0] | n.sticky;
      if (guard && (rest || mag[0])) mag = 16'(mag + 16'd1);
    end
    r = n.neg ? neg16(mag) : mag;
    if (n.special) r = n.special_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= vin;
    if (en) res_r <= r;
  end

endmodule
`default_nettype wire
